// ----- hdl/cbortd_pkg.sv -----
// package: shared types and constants for the cbor token stream decoder
`timescale 1ns / 1ps

package cbortd_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_TOKEN   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  // major types that the parser treats specially
  localparam logic [2:0] MT_NEG   = 3'd1;
  localparam logic [2:0] MT_BYTES = 3'd2;
  localparam logic [2:0] MT_TEXT  = 3'd3;
  localparam logic [2:0] MT_ARRAY = 3'd4;
  localparam logic [2:0] MT_MAP   = 3'd5;
  localparam logic [2:0] MT_PRIM  = 3'd7;

  // additional info codes
  localparam logic [4:0] AI_ARG_MIN     = 5'd24;
  localparam logic [4:0] AI_RESERVED_MIN = 5'd28;
  localparam logic [4:0] AI_RESERVED_MAX = 5'd30;
  localparam logic [4:0] AI_INDEF       = 5'd31;
  localparam logic [4:0] AI_SIMPLE_MIN  = 5'd20;

  localparam logic [7:0] BREAK_BYTE = 8'hFF;

  // one result item
  typedef struct packed {
    kind_t       result_kind;
    logic [2:0]  major_type;
    logic [4:0]  additional_info;
    logic [63:0] value;
    logic        value_wrapped;
    logic [7:0]  payload_byte;
    logic        last_payload;
  } result_t;

endpackage

// ----- hdl/cbortd_in_if.sv -----
// interface: input byte channel
`timescale 1ns / 1ps

interface cbortd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_start;

  modport source (output valid, output in_byte, output frame_start, input ready);
  modport sink   (input valid, input in_byte, input frame_start, output ready);
endinterface

// ----- hdl/cbortd_out_if.sv -----
// interface: result token channel
`timescale 1ns / 1ps

interface cbortd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [2:0]  major_type;
  logic [4:0]  additional_info;
  logic [63:0] value;
  logic        value_wrapped;
  logic [7:0]  payload_byte;
  logic        last_payload;

  modport source (
    output valid, output result_kind, output major_type, output additional_info,
    output value, output value_wrapped, output payload_byte, output last_payload,
    input ready
  );
  modport sink (
    input valid, input result_kind, input major_type, input additional_info,
    input value, input value_wrapped, input payload_byte, input last_payload,
    output ready
  );
endinterface

// ----- hdl/cbortd_parse.sv -----
// parser: per-byte state update and result generation
`timescale 1ns / 1ps

module cbortd_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          in_byte,
  input  logic                frame_start,
  output logic                res_valid,
  output cbortd_pkg::result_t res
);

  typedef enum logic [1:0] {
    PH_INITIAL    = 2'd0,
    PH_ARGUMENT   = 2'd1,
    PH_DEFINITE   = 2'd2,
    PH_INDEFINITE = 2'd3
  } phase_t;

  phase_t      phase, phase_next, eff_phase;
  logic [3:0]  arg_left, arg_left_next;
  logic [63:0] acc, acc_next;
  logic [2:0]  held_mt, held_mt_next;
  logic [4:0]  held_ai, held_ai_next;
  logic [63:0] pay_left, pay_left_next;
  logic [63:0] ind_count, ind_count_next;

  logic [2:0]  mt;
  logic [4:0]  ai;
  logic [4:0]  small_arg;
  logic [63:0] acc_sh;
  logic [3:0]  arg_left_dec;
  logic [63:0] fin_arg;
  logic [63:0] fin_inc;
  logic [2:0]  fin_mt;
  logic        do_finish;

  // byte fields and shared arithmetic
  assign mt           = in_byte[7:5];
  assign ai           = in_byte[4:0];
  assign eff_phase    = frame_start ? PH_INITIAL : phase;
  assign small_arg    = (mt == cbortd_pkg::MT_PRIM && ai >= cbortd_pkg::AI_SIMPLE_MIN)
                        ? 5'd0 : ai;
  assign acc_sh       = {acc[55:0], in_byte};
  assign arg_left_dec = arg_left - 4'd1;
  assign fin_arg      = (eff_phase == PH_ARGUMENT) ? acc_sh : {59'd0, small_arg};
  assign fin_mt       = (eff_phase == PH_ARGUMENT) ? held_mt : mt;
  assign fin_inc      = fin_arg + 64'd1;

  // next state and result
  always_comb begin
    phase_next     = phase;
    arg_left_next  = arg_left;
    acc_next       = acc;
    held_mt_next   = held_mt;
    held_ai_next   = held_ai;
    pay_left_next  = pay_left;
    ind_count_next = ind_count;
    do_finish      = 1'b0;
    res_valid      = 1'b0;
    res            = '0;

    unique case (eff_phase)
      PH_ARGUMENT: begin
        acc_next      = acc_sh;
        arg_left_next = arg_left_dec;
        if (arg_left_dec == 4'd0) begin
          do_finish = 1'b1;
        end
      end
      PH_DEFINITE: begin
        pay_left_next    = pay_left - 64'd1;
        res_valid        = 1'b1;
        res.result_kind  = cbortd_pkg::KIND_PAYLOAD;
        res.payload_byte = in_byte;
        if (pay_left == 64'd1) begin
          phase_next       = PH_INITIAL;
          res.last_payload = 1'b1;
        end
      end
      PH_INDEFINITE: begin
        res_valid = 1'b1;
        if (in_byte == cbortd_pkg::BREAK_BYTE) begin
          res.result_kind = cbortd_pkg::KIND_END;
          res.value       = ind_count;
          ind_count_next  = '0;
          phase_next      = PH_INITIAL;
        end else begin
          res.result_kind  = cbortd_pkg::KIND_PAYLOAD;
          res.payload_byte = in_byte;
          ind_count_next   = ind_count + 64'd1;
        end
      end
      PH_INITIAL: begin
        held_mt_next  = mt;
        held_ai_next  = ai;
        acc_next      = '0;
        arg_left_next = '0;
        phase_next    = PH_INITIAL;
        if (frame_start) begin
          pay_left_next  = '0;
          ind_count_next = '0;
        end
        if (ai >= cbortd_pkg::AI_RESERVED_MIN && ai <= cbortd_pkg::AI_RESERVED_MAX) begin
          res_valid       = 1'b1;
          res.result_kind = cbortd_pkg::KIND_ERROR;
        end else if (ai == cbortd_pkg::AI_INDEF) begin
          if (mt == cbortd_pkg::MT_BYTES || mt == cbortd_pkg::MT_TEXT) begin
            ind_count_next = '0;
            phase_next     = PH_INDEFINITE;
          end else if (mt == cbortd_pkg::MT_ARRAY || mt == cbortd_pkg::MT_MAP
                       || mt == cbortd_pkg::MT_PRIM) begin
            res_valid       = 1'b1;
            res.result_kind = cbortd_pkg::KIND_TOKEN;
          end else begin
            res_valid       = 1'b1;
            res.result_kind = cbortd_pkg::KIND_ERROR;
          end
        end else if (ai >= cbortd_pkg::AI_ARG_MIN) begin
          arg_left_next = 4'd1 << ai[1:0];
          phase_next    = PH_ARGUMENT;
        end else begin
          do_finish = 1'b1;
        end
      end
      default: begin
        phase_next = PH_INITIAL;
      end
    endcase

    // finish any token: negative offset, definite string start
    if (do_finish) begin
      res_valid       = 1'b1;
      res.result_kind = cbortd_pkg::KIND_TOKEN;
      phase_next      = PH_INITIAL;
      if (fin_mt == cbortd_pkg::MT_NEG) begin
        res.value         = fin_inc;
        res.value_wrapped = (fin_inc == 64'd0);
      end else begin
        res.value = fin_arg;
        if ((fin_mt == cbortd_pkg::MT_BYTES || fin_mt == cbortd_pkg::MT_TEXT)
            && fin_arg != 64'd0) begin
          pay_left_next = fin_arg;
          phase_next    = PH_DEFINITE;
        end
      end
    end

    res.major_type      = held_mt_next;
    res.additional_info = held_ai_next;
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_INITIAL;
      arg_left  <= '0;
      acc       <= '0;
      held_mt   <= '0;
      held_ai   <= '0;
      pay_left  <= '0;
      ind_count <= '0;
    end else if (take) begin
      phase     <= phase_next;
      arg_left  <= arg_left_next;
      acc       <= acc_next;
      held_mt   <= held_mt_next;
      held_ai   <= held_ai_next;
      pay_left  <= pay_left_next;
      ind_count <= ind_count_next;
    end
  end

  // invariants of the parse state
  a_arg_left_nonzero : assert property (@(posedge clk) disable iff (rst)
    phase == PH_ARGUMENT |-> arg_left != 4'd0)
    else $error("argument phase with no bytes left");

  a_pay_left_nonzero : assert property (@(posedge clk) disable iff (rst)
    phase == PH_DEFINITE |-> pay_left != 64'd0)
    else $error("definite string phase with no payload left");

  a_arg_left_width : assert property (@(posedge clk) disable iff (rst)
    phase == PH_ARGUMENT |-> arg_left <= 4'd8)
    else $error("argument count out of range");

  a_hold_when_idle : assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(phase) && $stable(acc))
    else $error("parse state moved without an item");

endmodule

// ----- hdl/cbor_token_stream_decoder_top.sv -----
// top level: cbor token stream decoder with a two-entry result buffer
//
//   channel  modport  payload                                   width
//   stream   sink     in_byte, frame_start                      8 + 1
//   tokens   source   result_kind, major_type, additional_info, 2+3+5+64+1+8+1
//                     value, value_wrapped, payload_byte,
//                     last_payload
//
// one byte per cycle while ready; each byte is decoded in the cycle it is
// accepted and its result goes to the output register or the skid register.
// the result path is an output register plus a skid register, so the input
// stays ready while one result waits; it stalls only when both hold results.
// synchronous active-high rst clears parse state and the result buffer.
`timescale 1ns / 1ps

module cbor_token_stream_decoder_top (
  input  logic         clk,
  input  logic         rst,
  cbortd_in_if.sink    stream,
  cbortd_out_if.source tokens
);

  logic                take;
  logic                res_valid;
  cbortd_pkg::result_t res;
  logic                o_valid;
  cbortd_pkg::result_t o_data;
  logic                s_valid;
  cbortd_pkg::result_t s_data;
  logic                o_take;

  assign stream.ready = !s_valid;
  assign take         = stream.valid && stream.ready;
  assign o_take       = o_valid && tokens.ready;

  cbortd_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .in_byte     (stream.in_byte),
    .frame_start (stream.frame_start),
    .res_valid   (res_valid),
    .res         (res)
  );

  // result register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (s_valid) begin
      if (o_take) begin
        o_data  <= s_data;
        s_valid <= 1'b0;
      end
    end else if (take && res_valid) begin
      if (!o_valid || o_take) begin
        o_data  <= res;
        o_valid <= 1'b1;
      end else begin
        s_data  <= res;
        s_valid <= 1'b1;
      end
    end else if (o_take) begin
      o_valid <= 1'b0;
    end
  end

  assign tokens.valid           = o_valid;
  assign tokens.result_kind     = o_data.result_kind;
  assign tokens.major_type      = o_data.major_type;
  assign tokens.additional_info = o_data.additional_info;
  assign tokens.value           = o_data.value;
  assign tokens.value_wrapped   = o_data.value_wrapped;
  assign tokens.payload_byte    = o_data.payload_byte;
  assign tokens.last_payload    = o_data.last_payload;

  // buffer ordering and occupancy
  a_skid_needs_out : assert property (@(posedge clk) disable iff (rst)
    s_valid |-> o_valid)
    else $error("skid holds a result while output is empty");

  a_skid_fills : assert property (@(posedge clk) disable iff (rst)
    o_valid && !tokens.ready && !s_valid && take && res_valid |=> s_valid)
    else $error("result dropped while output stalled");

  a_skid_drains : assert property (@(posedge clk) disable iff (rst)
    s_valid && tokens.ready |=> !s_valid && o_valid && o_data == $past(s_data))
    else $error("skid result not moved to output");

endmodule
